/* rtl/core/lfal_pkg.sv */
// lfal_pkg: shared types and constants of the failed-attempt lockout table
// no dependencies
`default_nettype none

package lfal_pkg;

  localparam int LFAL_ENTRIES = 3;

  localparam int ADDR_W   = 32;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 8;
  localparam int WINDOW_W = 16;
  localparam int STATUS_W = 2;

  localparam logic [COUNT_W-1:0]  THRESHOLD_RST    = 8'd3;
  localparam logic [WINDOW_W-1:0] LONG_WINDOW_RST  = 16'd900;
  localparam logic [WINDOW_W-1:0] SHORT_WINDOW_RST = 16'd15;
  localparam logic                SHORT_EN_RST     = 1'b1;

  localparam logic [COUNT_W-1:0]  COUNT_MAX = 8'hFF;

  localparam logic OP_CHECK  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [7:0] CFG_THRESHOLD    = 8'd0;
  localparam logic [7:0] CFG_LONG_WINDOW  = 8'd1;
  localparam logic [7:0] CFG_SHORT_WINDOW = 8'd2;
  localparam logic [7:0] CFG_SHORT_EN     = 8'd3;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_LONG  = 2'd2
  } status_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  lock_threshold;
    logic [WINDOW_W-1:0] long_window;
    logic [WINDOW_W-1:0] short_window;
    logic                short_lock_enable;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/lfal_status.sv */
// lfal_status: elapsed-time subtract and lockout decision for one entry
// depends on lfal_pkg
`default_nettype none

module lfal_status
  import lfal_pkg::*;
(
  input  cfg_t               cfg,
  input  logic [COUNT_W-1:0] count,
  input  logic [TIME_W-1:0]  fail_time,
  input  logic [TIME_W-1:0]  now,
  output status_t            status
);

  logic [TIME_W-1:0] elapsed;

  assign elapsed = now - fail_time;

  always_comb begin
    status = STATUS_OK;
    priority if (count >= cfg.lock_threshold) begin
      if (elapsed <= TIME_W'(cfg.long_window)) status = STATUS_LONG;
    end else if (count != '0 && cfg.short_lock_enable) begin
      if (elapsed <= TIME_W'(cfg.short_window)) status = STATUS_SHORT;
    end else begin
      status = STATUS_OK;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lru_failed_attempt_lockout.sv */
// lru_failed_attempt_lockout: recency-ordered client table with lockout status
// depends on lfal_pkg and lfal_status
//
//   channel  signals                                             direction
//   in       in_valid/in_ready, in_op, in_client_addr,           input
//            in_failed, in_now_seconds
//   out      out_valid/out_ready, out_status                     output
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data            input
//
// a check item scans k = 1..ENTRIES slots with the single address comparator,
// one slot per cycle; the hit or insert and the move to front finish in ST_MOVE
// a report item passes through ST_RPT; it gives no result
// the block is not ready while an item is in work; a waiting result holds
// only the move-to-front cycle of the next check item
// reset clears the valid bits and loads the register defaults; cfg is always ready
`default_nettype none

module lru_failed_attempt_lockout
  import lfal_pkg::*;
#(
  parameter int ENTRIES = LFAL_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [ADDR_W-1:0]     in_client_addr,
  input  logic                  in_failed,
  input  logic [TIME_W-1:0]     in_now_seconds,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_index,
  input  logic [WINDOW_W-1:0]   cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_MOVE = 4'b0100,
    ST_RPT  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                hit_r, hit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  cfg_t                cfg_r;

  logic [ENTRIES-1:0]  valid_r;
  logic [ADDR_W-1:0]   addr_r  [ENTRIES];
  logic [COUNT_W-1:0]  count_r [ENTRIES];
  logic [TIME_W-1:0]   time_r  [ENTRIES];

  logic [ADDR_W-1:0]   item_addr_r;
  logic                item_failed_r;
  logic [TIME_W-1:0]   item_now_r;

  logic                addr_hit;
  logic                move_go;
  status_t             unit_status;

  assign in_ready   = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  assign addr_hit = (addr_r[idx_r] == item_addr_r);
  assign move_go  = (state_r == ST_MOVE) && (!out_valid_r || out_ready);

  lfal_status u_status (
    .cfg       (cfg_r),
    .count     (count_r[idx_r]),
    .fail_time (time_r[idx_r]),
    .now       (item_now_r),
    .status    (unit_status)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = (in_op == OP_REPORT) ? ST_RPT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (!valid_r[idx_r]) begin
          state_nxt = ST_MOVE;
        end else if (addr_hit) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_MOVE;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_MOVE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_MOVE: begin
        if (move_go) state_nxt = ST_IDLE;
      end
      ST_RPT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (move_go) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      cfg_r.lock_threshold    <= THRESHOLD_RST;
      cfg_r.long_window       <= LONG_WINDOW_RST;
      cfg_r.short_window      <= SHORT_WINDOW_RST;
      cfg_r.short_lock_enable <= SHORT_EN_RST;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      if (move_go) begin
        valid_r[0] <= 1'b1;
        for (int j = 1; j < ENTRIES; j++) begin
          if (IDX_W'(j) <= idx_r) valid_r[j] <= valid_r[j-1];
        end
      end
      if (cfg_valid) begin
        priority case (cfg_index)
          CFG_THRESHOLD:    cfg_r.lock_threshold    <= cfg_data[COUNT_W-1:0];
          CFG_LONG_WINDOW:  cfg_r.long_window       <= cfg_data;
          CFG_SHORT_WINDOW: cfg_r.short_window      <= cfg_data;
          CFG_SHORT_EN:     cfg_r.short_lock_enable <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_addr_r   <= in_client_addr;
      item_failed_r <= in_failed;
      item_now_r    <= in_now_seconds;
    end
    if (move_go) begin
      out_status_r <= hit_r ? unit_status : STATUS_OK;
      addr_r[0]    <= hit_r ? addr_r[idx_r]  : item_addr_r;
      count_r[0]   <= hit_r ? count_r[idx_r] : '0;
      time_r[0]    <= hit_r ? time_r[idx_r]  : item_now_r;
      for (int j = 1; j < ENTRIES; j++) begin
        if (IDX_W'(j) <= idx_r) begin
          addr_r[j]  <= addr_r[j-1];
          count_r[j] <= count_r[j-1];
          time_r[j]  <= time_r[j-1];
        end
      end
    end
    if (state_r == ST_RPT && valid_r[0]) begin
      // failure saturates, success clears
      if (item_failed_r) begin
        if (count_r[0] != COUNT_MAX) count_r[0] <= count_r[0] + 1'b1;
      end else begin
        count_r[0] <= '0;
      end
      time_r[0] <= item_now_r;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/lru_failed_attempt_lockout_test.sv */
// lru_failed_attempt_lockout_test: self-checking bench for the lockout table
// depends on lfal_pkg and lru_failed_attempt_lockout; predicts each status in-line
// and checks results in order under random stalls on both channels
`default_nettype none

module lru_failed_attempt_lockout_test
  import lfal_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] REG_UNUSED_TOP   = 8'hFF;

  localparam int LONG_HOLD      = 80;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int POOL_SIZE      = 5;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic              failed;
    logic [TIME_W-1:0] stamp;
  } login_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_op = OP_CHECK;
  logic [ADDR_W-1:0]   in_client_addr = '0;
  logic                in_failed = 1'b0;
  logic [TIME_W-1:0]   in_now_seconds = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_index = '0;
  logic [WINDOW_W-1:0] cfg_data = '0;

  lru_failed_attempt_lockout DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_client_addr (in_client_addr),
    .in_failed      (in_failed),
    .in_now_seconds (in_now_seconds),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted table and registers
  cfg_t              lockout_cfg = '{THRESHOLD_RST, LONG_WINDOW_RST, SHORT_WINDOW_RST,
                                     SHORT_EN_RST};
  bit                tbl_valid [LFAL_ENTRIES];
  logic [ADDR_W-1:0] tbl_addr  [LFAL_ENTRIES];
  logic [COUNT_W-1:0] tbl_count [LFAL_ENTRIES];
  logic [TIME_W-1:0] tbl_time  [LFAL_ENTRIES];

  login_item_t pending_items[$];
  status_t     expected_status[$];
  login_item_t offered_item;
  status_t     oldest_status;

  bit          idle_enable = 1'b1;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  int          holds_requested = 0;
  int          holds_started = 0;
  int          idle_cycles = 0;
  int          mismatches = 0;
  int          checks_seen = 0;
  int          reports_seen = 0;
  int          results_seen = 0;
  int          long_locks = 0;
  int          short_locks = 0;
  int          cfg_writes = 0;
  logic [TIME_W-1:0] sim_now = 32'd100000;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic promote_slot(input int src);
    bit                 v;
    logic [ADDR_W-1:0]  a;
    logic [COUNT_W-1:0] c;
    logic [TIME_W-1:0]  t;
    v = tbl_valid[src];
    a = tbl_addr[src];
    c = tbl_count[src];
    t = tbl_time[src];
    for (int i = src; i > 0; i--) begin
      tbl_valid[i] = tbl_valid[i-1];
      tbl_addr[i]  = tbl_addr[i-1];
      tbl_count[i] = tbl_count[i-1];
      tbl_time[i]  = tbl_time[i-1];
    end
    tbl_valid[0] = v;
    tbl_addr[0]  = a;
    tbl_count[0] = c;
    tbl_time[0]  = t;
  endtask

  task automatic predict_lockout(input login_item_t it);
    int                hit;
    int                used;
    int                slot;
    logic [TIME_W-1:0] elapsed;
    status_t           st;
    hit = -1;
    used = 0;
    st = STATUS_OK;
    if (it.op == OP_REPORT) begin
      reports_seen++;
      if (tbl_valid[0]) begin
        if (it.failed) begin
          if (tbl_count[0] != COUNT_MAX) tbl_count[0]++;
        end else begin
          tbl_count[0] = '0;
        end
        tbl_time[0] = it.stamp;
      end
      return;
    end
    checks_seen++;
    for (int i = 0; i < LFAL_ENTRIES; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_addr[i] == it.addr) hit = i;
      if (tbl_valid[i]) used++;
    end
    if (hit >= 0) begin
      elapsed = it.stamp - tbl_time[hit];
      if (tbl_count[hit] >= lockout_cfg.lock_threshold) begin
        if (elapsed <= {16'd0, lockout_cfg.long_window}) st = STATUS_LONG;
      end else if (tbl_count[hit] != 0 && lockout_cfg.short_lock_enable) begin
        if (elapsed <= {16'd0, lockout_cfg.short_window}) st = STATUS_SHORT;
      end
      promote_slot(hit);
    end else begin
      slot = (used < LFAL_ENTRIES) ? used : LFAL_ENTRIES - 1;
      tbl_valid[slot] = 1'b1;
      tbl_addr[slot]  = it.addr;
      tbl_count[slot] = '0;
      tbl_time[slot]  = it.stamp;
      promote_slot(slot);
    end
    if (st == STATUS_LONG) long_locks++;
    if (st == STATUS_SHORT) short_locks++;
    expected_status.push_back(st);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_lockout(offered_item);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        offered_item = pending_items.pop_front();
        in_valid       <= 1'b1;
        in_op          <= offered_item.op;
        in_client_addr <= offered_item.addr;
        in_failed      <= offered_item.failed;
        in_now_seconds <= offered_item.stamp;
        send_gap = idle_enable ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          $error("out_status: no result expected, actual %0d", out_status);
          mismatches++;
        end else begin
          oldest_status = expected_status.pop_front();
          results_seen++;
          if (out_status !== oldest_status) begin
            $error("out_status: expected %0d, actual %0d", oldest_status, out_status);
            mismatches++;
          end
        end
        recv_gap = idle_enable ? pick_gap() : 0;
      end
      if (hold_left == 0 && holds_started != holds_requested) begin
        holds_started++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no item moved for %0d cycles", idle_cycles);
      $display("[lru_failed_attempt_lockout] ERROR");
      $finish;
    end
  end

  task automatic write_register(input logic [7:0] idx, input logic [WINDOW_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_THRESHOLD:    lockout_cfg.lock_threshold = data[COUNT_W-1:0];
      CFG_LONG_WINDOW:  lockout_cfg.long_window = data;
      CFG_SHORT_WINDOW: lockout_cfg.short_window = data;
      CFG_SHORT_EN:     lockout_cfg.short_lock_enable = data[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_registers(input logic [15:0] thr_data, input logic [15:0] long_win,
                               input logic [15:0] short_win, input logic [15:0] en_data);
    write_register(CFG_THRESHOLD, thr_data);
    write_register(CFG_LONG_WINDOW, long_win);
    write_register(CFG_SHORT_WINDOW, short_win);
    write_register(CFG_SHORT_EN, en_data);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_check(input logic [ADDR_W-1:0] a, input logic [TIME_W-1:0] t);
    login_item_t it;
    it = '{OP_CHECK, a, 1'($urandom), t};
    pending_items.push_back(it);
  endtask

  task automatic push_report(input logic f, input logic [TIME_W-1:0] t);
    login_item_t it;
    it = '{OP_REPORT, 32'($urandom), f, t};
    pending_items.push_back(it);
  endtask

  task automatic advance_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) sim_now += $urandom_range(0, 20);
    else if (r < 85) sim_now += $urandom_range(0, 1500);
    else if (r < 93) sim_now -= $urandom_range(1, 30);
    else if (r < 97) sim_now += $urandom_range(0, 70000);
    else sim_now = $urandom;
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 9) < 8) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic queue_traffic(input int n);
    int                made;
    int                r;
    int                k;
    logic [ADDR_W-1:0] a;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      advance_clock();
      if (r < 55) begin
        a = pick_addr();
        push_check(a, sim_now);
        k = $urandom_range(0, 4);
        repeat (k) begin
          advance_clock();
          push_report($urandom_range(0, 5) != 0, sim_now);
        end
        made += k + 1;
        if ($urandom_range(0, 1)) begin
          advance_clock();
          push_check(a, sim_now);
          made++;
        end
      end else if (r < 85) begin
        push_check(pick_addr(), sim_now);
        made++;
      end else begin
        push_report(1'($urandom), sim_now);
        made++;
      end
    end
  endtask

  task automatic run_traffic(input int n, input bit gappy, input bit long_hold);
    @(negedge clk);
    idle_enable = gappy;
    if (long_hold) holds_requested++;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    queue_traffic(n);
    wait_idle();
  endtask

  task automatic queue_saturation();
    logic [ADDR_W-1:0] a;
    a = $urandom;
    @(negedge clk);
    idle_enable = 1'b0;
    push_check(a, sim_now);
    repeat (300) push_report(1'b1, sim_now);
    push_check(a, sim_now + 32'd5);
    push_report(1'b0, sim_now + 32'd5);
    push_check(a, sim_now + 32'd6);
    wait_idle();
  endtask

  task automatic queue_directed();
    push_report(1'b1, 32'd100);
    push_report(1'b0, 32'd100);
    push_check(32'h0A000001, 32'd1000);
    push_check(32'h0A000001, 32'd1000);
    push_report(1'b1, 32'd1000);
    push_check(32'h0A000001, 32'd1015);
    push_check(32'h0A000001, 32'd1016);
    push_report(1'b1, 32'd1016);
    push_report(1'b1, 32'd1020);
    push_check(32'h0A000001, 32'd1920);
    push_check(32'h0A000001, 32'd1921);
    push_report(1'b0, 32'd1921);
    push_check(32'h0A000001, 32'd1921);
    push_check(32'h00000000, 32'h00000000);
    push_check(32'hFFFFFFFF, 32'hFFFFFFFF);
    push_check(32'h0B000002, 32'd2000);
    push_check(32'h0A000001, 32'd2000);
    push_report(1'b1, 32'd5000);
    push_check(32'h0A000001, 32'd4999);
    push_check(32'hFFFFFFFF, 32'hFFFFFFFF);
    push_report(1'b1, 32'hFFFFFFFA);
    push_check(32'hFFFFFFFF, 32'h00000002);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    queue_directed();
    wait_idle();

    set_registers(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    run_traffic(150, 1'b0, 1'b1);
    write_register(REG_UNUSED_TOP, 16'hFFFF);
    write_register(8'($urandom_range(4, 254)), 16'($urandom));

    set_registers(16'h00FF, 16'hFFFF, 16'hFFFF, 16'h0001);
    queue_saturation();
    run_traffic(150, 1'b1, 1'b0);

    set_registers(16'hFF00, 16'd900, 16'd15, 16'hFFFF);
    run_traffic(150, 1'b1, 1'b0);

    repeat (4) begin
      set_registers({8'($urandom), 8'($urandom_range(1, 6))}, 16'($urandom_range(0, 2000)),
                    16'($urandom_range(0, 60)), {15'($urandom), 1'($urandom)});
      run_traffic(150, 1'($urandom), 1'b0);
    end

    set_registers({8'd0, THRESHOLD_RST}, LONG_WINDOW_RST, SHORT_WINDOW_RST,
                  {15'd0, SHORT_EN_RST});
    run_traffic(150, 1'b1, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d results never arrived", expected_status.size());
      mismatches++;
    end
    $display("covered %0d checks, %0d reports, %0d results, %0d register writes",
             checks_seen, reports_seen, results_seen, cfg_writes);
    $display("lockouts predicted: %0d long, %0d short", long_locks, short_locks);
    if (mismatches == 0) begin
      $display("[lru_failed_attempt_lockout] OK");
    end else begin
      $display("[lru_failed_attempt_lockout] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/core/lfal_pkg.sv
rtl/core/lfal_status.sv
rtl/core/lru_failed_attempt_lockout.sv
tb/sv/lru_failed_attempt_lockout_test.sv
